>>> design/mvta_pkg.sv
// ----------------------------------------------------------------------------
// mvta_pkg
// Shared constants, types and helpers of the mesh vertex tangent accumulator.
// ----------------------------------------------------------------------------
package mvta_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int VADDR_W      = $clog2(MAX_VERTICES);

	localparam int IDX_W    = 10;
	localparam int CRD_W    = 32;
	localparam int VTX_W    = 5 * CRD_W;
	localparam int ACC_W    = 24;
	localparam int SUM_W    = 3 * ACC_W;
	localparam int TAN_W    = 16;
	localparam int MAG_W    = 65;
	localparam int PRD_W    = 67;
	localparam int M_W      = 30;
	localparam int S_DATA_W = 192;
	localparam int M_DATA_W = 48;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_TRI   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;

	typedef struct packed {
		logic       start;
		logic [2:0] neg;
	} norm_ctl_t;

	typedef struct packed {
		logic done;
		logic zero;
	} norm_sts_t;

	function automatic logic idx_ok(input logic [IDX_W-1:0] i);
		return int'(i) < MAX_VERTICES;
	endfunction

	// {clipped, new sum}
	function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] s,
			input logic signed [TAN_W-1:0] q);
		logic signed [ACC_W:0] t;
		t = (ACC_W+1)'(s) + (ACC_W+1)'(q);
		if (t > (ACC_W+1)'(ACC_MAX))
			return {1'b1, ACC_MAX};
		else if (t < (ACC_W+1)'(ACC_MIN))
			return {1'b1, ACC_MIN};
		else
			return {1'b0, t[ACC_W-1:0]};
	endfunction

endpackage

>>> design/mesh_vertex_tangent_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_tangent_accumulator
// Per-vertex tangent accumulation from UV-mapped triangles.
// ----------------------------------------------------------------------------
// Input channel s_axis carries one command item: load a vertex, add a
// triangle, read a vertex tangent or clear all sums (kind in tuser).
// Output channel m_axis returns exactly one item per command, in order.
// Vertices live in a 1024 x 160 RAM, tangent sums in a 1024 x 72 RAM.
// One item at a time; the time per item is mostly set by the serial normalizer
// (shift search, square root, three divisions). A read normalizes the stored
// sum; a triangle does 3 vertex reads, 8 multiplies, a normalize and 3
// read-modify-write passes on the sum RAM, and ends early when degenerate.
// Reset (or a clear item) sweeps the sum RAM to zero, one entry a cycle;
// s_axis_tready stays low meanwhile.
// A result waits in the output register while the next item is accepted;
// a stalled receiver only stalls the block once a second result is ready.
// ----------------------------------------------------------------------------
module mesh_vertex_tangent_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// vertex_index, second_index, third_index, pos_x, pos_y, pos_z, tex_u, tex_v, pad
	input  logic [mvta_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// action
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tangent_x, tangent_y, tangent_z
	output logic [mvta_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// degenerate, saturated
	output logic [1:0]                      m_axis_tuser
);
	import mvta_pkg::*;

	localparam logic [4:0] ST_CLR   = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RD0   = 5'd2;
	localparam logic [4:0] ST_RD1   = 5'd3;
	localparam logic [4:0] ST_RNORM = 5'd4;
	localparam logic [4:0] ST_V0    = 5'd5;
	localparam logic [4:0] ST_V1    = 5'd6;
	localparam logic [4:0] ST_V2    = 5'd7;
	localparam logic [4:0] ST_V3    = 5'd8;
	localparam logic [4:0] ST_DIFF  = 5'd9;
	localparam logic [4:0] ST_ABS   = 5'd10;
	localparam logic [4:0] ST_MUL   = 5'd11;
	localparam logic [4:0] ST_MWAIT = 5'd12;
	localparam logic [4:0] ST_SGN   = 5'd13;
	localparam logic [4:0] ST_TNORM = 5'd14;
	localparam logic [4:0] ST_ACRD  = 5'd15;
	localparam logic [4:0] ST_ACWR  = 5'd16;
	localparam logic [4:0] ST_RES   = 5'd17;

	// control
	logic [4:0]         state_q;
	logic [VADDR_W-1:0] clr_cnt_q;
	logic               clr_item_q;
	logic [2:0]         k_q;
	logic [1:0]         corner_q;
	logic               vld_s1;
	logic               vld_s2;
	logic               out_valid_q;

	// payload
	logic [IDX_W-1:0]        idx_q [3];
	logic [VTX_W-1:0]        v_q [3];
	logic signed [32:0]      d_q [10];
	logic [31:0]             dm_q [10];
	logic [9:0]              dn_q;
	logic [63:0]             prod_s1;
	logic                    neg_s1;
	logic [2:0]              k_s1;
	logic signed [PRD_W-1:0] sp_s2;
	logic [2:0]              k_s2;
	logic signed [PRD_W-1:0] p_q;
	logic signed [PRD_W-1:0] res_q [4];
	logic signed [TAN_W-1:0] tq_q [3];
	logic signed [TAN_W-1:0] qt_q [3];
	logic                    deg_q;
	logic                    sat_q;
	logic [M_DATA_W-1:0]     out_data_q;
	logic [1:0]              out_user_q;

	logic               accept;
	logic [IDX_W-1:0]   in_idx [3];
	logic [VTX_W-1:0]   in_vtx;
	logic               tri_ok;
	logic [IDX_W-1:0]   cur_idx;
	logic [VTX_W-1:0]   vram_rdata;
	logic [SUM_W-1:0]   sram_rdata;
	logic               sram_we;
	logic [VADDR_W-1:0] sram_waddr;
	logic [SUM_W-1:0]   sram_wdata;
	logic [VADDR_W-1:0] vram_raddr;
	logic [3:0]         ai;
	logic [3:0]         bi;
	logic [ACC_W:0]     acc [3];
	logic               res_load;

	norm_ctl_t               nctl;
	norm_sts_t               nsts;
	logic [MAG_W-1:0]        nmag [3];
	logic signed [TAN_W-1:0] nq [3];
	logic signed [ACC_W-1:0] rs;
	logic [ACC_W-1:0]        rmag;
	logic signed [PRD_W-1:0] tv;
	logic [PRD_W-1:0]        tmag;
	logic                    det_neg;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_idx[0] = s_axis_tdata[IDX_W-1:0];
	assign in_idx[1] = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_idx[2] = s_axis_tdata[3*IDX_W-1:2*IDX_W];
	assign in_vtx    = s_axis_tdata[3*IDX_W +: VTX_W];
	assign tri_ok    = idx_ok(in_idx[0]) && idx_ok(in_idx[1]) && idx_ok(in_idx[2]);
	assign res_load  = (state_q == ST_RES) && (!out_valid_q || m_axis_tready);

	always_comb begin
		case (corner_q)
			2'd0:    cur_idx = idx_q[0];
			2'd1:    cur_idx = idx_q[1];
			default: cur_idx = idx_q[2];
		endcase
		case (state_q)
			ST_V0:   vram_raddr = VADDR_W'(idx_q[0]);
			ST_V1:   vram_raddr = VADDR_W'(idx_q[1]);
			default: vram_raddr = VADDR_W'(idx_q[2]);
		endcase
	end

	mvta_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vram (
		.clk   (clk),
		.we    (accept && s_axis_tuser == ACT_LOAD && idx_ok(in_idx[0])),
		.waddr (VADDR_W'(in_idx[0])),
		.wdata (in_vtx),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	// saturating accumulate on the sum RAM read data
	always_comb begin
		for (int i = 0; i < 3; i++)
			acc[i] = sat_add(sram_rdata[i*ACC_W +: ACC_W], tq_q[i]);
		sram_we    = (state_q == ST_CLR) || (state_q == ST_ACWR);
		sram_waddr = (state_q == ST_CLR) ? clr_cnt_q : VADDR_W'(cur_idx);
		sram_wdata = (state_q == ST_CLR) ? '0 :
			{acc[2][ACC_W-1:0], acc[1][ACC_W-1:0], acc[0][ACC_W-1:0]};
	end

	mvta_ram #(.WIDTH(SUM_W), .DEPTH(MAX_VERTICES)) u_sram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (sram_waddr),
		.wdata (sram_wdata),
		.raddr ((state_q == ST_ACRD) ? VADDR_W'(cur_idx) : VADDR_W'(idx_q[0])),
		.rdata (sram_rdata)
	);

	// normalizer feed: read sums or triangle tangent
	always_comb begin
		det_neg   = res_q[0] < 0;
		nctl.neg  = '0;
		nctl.start = ((state_q == ST_RD1) && idx_ok(idx_q[0])) ||
			((state_q == ST_SGN) && (res_q[0] != '0));
		for (int i = 0; i < 3; i++) begin
			rs   = sram_rdata[i*ACC_W +: ACC_W];
			rmag = rs[ACC_W-1] ? ACC_W'(-rs) : ACC_W'(rs);
			tv   = res_q[i+1];
			tmag = tv[PRD_W-1] ? PRD_W'(-tv) : PRD_W'(tv);
			if (state_q == ST_SGN) begin
				nmag[i]     = tmag[MAG_W-1:0];
				nctl.neg[i] = tv[PRD_W-1] ^ det_neg;
			end else begin
				nmag[i]     = MAG_W'(rmag);
				nctl.neg[i] = rs[ACC_W-1];
			end
		end
	end

	mvta_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (nctl),
		.mag_x  (nmag[0]),
		.mag_y  (nmag[1]),
		.mag_z  (nmag[2]),
		.sts    (nsts),
		.q_x    (nq[0]),
		.q_y    (nq[1]),
		.q_z    (nq[2])
	);

	// product operands: du1*dv2, du2*dv1, then dv2*e1 and dv1*e2 per axis
	always_comb begin
		case (k_q)
			3'd0:    begin ai = 4'd0; bi = 4'd3; end
			3'd1:    begin ai = 4'd2; bi = 4'd1; end
			3'd2:    begin ai = 4'd3; bi = 4'd4; end
			3'd3:    begin ai = 4'd1; bi = 4'd7; end
			3'd4:    begin ai = 4'd3; bi = 4'd5; end
			3'd5:    begin ai = 4'd1; bi = 4'd8; end
			3'd6:    begin ai = 4'd3; bi = 4'd6; end
			default: begin ai = 4'd1; bi = 4'd9; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			clr_item_q  <= 1'b0;
			k_q         <= '0;
			corner_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_MUL);
			vld_s2 <= vld_s1;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == VADDR_W'(MAX_VERTICES - 1))
						state_q <= clr_item_q ? ST_RES : ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_axis_tuser)
							ACT_LOAD: state_q <= ST_RES;
							ACT_TRI:  state_q <= tri_ok ? ST_V0 : ST_RES;
							ACT_READ: state_q <= ST_RD0;
							default: begin
								clr_cnt_q  <= '0;
								clr_item_q <= 1'b1;
								state_q    <= ST_CLR;
							end
						endcase
					end
				end
				ST_RD0:   state_q <= ST_RD1;
				ST_RD1:   state_q <= idx_ok(idx_q[0]) ? ST_RNORM : ST_RES;
				ST_RNORM: if (nsts.done) state_q <= ST_RES;
				ST_V0:    state_q <= ST_V1;
				ST_V1:    state_q <= ST_V2;
				ST_V2:    state_q <= ST_V3;
				ST_V3:    state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_ABS;
				ST_ABS: begin
					k_q     <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7)
						state_q <= ST_MWAIT;
				end
				ST_MWAIT: if (vld_s2 && k_s2 == 3'd7) state_q <= ST_SGN;
				ST_SGN:   state_q <= (res_q[0] == '0) ? ST_RES : ST_TNORM;
				ST_TNORM: begin
					if (nsts.done) begin
						corner_q <= '0;
						state_q  <= nsts.zero ? ST_RES : ST_ACRD;
					end
				end
				ST_ACRD:  state_q <= ST_ACWR;
				ST_ACWR: begin
					corner_q <= corner_q + 2'd1;
					state_q  <= (corner_q == 2'd2) ? ST_RES : ST_ACRD;
				end
				ST_RES:   if (res_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				idx_q[i] <= in_idx[i];
				qt_q[i]  <= '0;
			end
			deg_q <= (s_axis_tuser == ACT_TRI) && !tri_ok;
			sat_q <= 1'b0;
		end
		case (state_q)
			ST_V1: v_q[0] <= vram_rdata;
			ST_V2: v_q[1] <= vram_rdata;
			ST_V3: v_q[2] <= vram_rdata;
			default: ;
		endcase
		if (state_q == ST_DIFF) begin
			d_q[0] <= $signed({v_q[1][3*CRD_W+CRD_W-1], v_q[1][3*CRD_W +: CRD_W]})
				- $signed({v_q[0][3*CRD_W+CRD_W-1], v_q[0][3*CRD_W +: CRD_W]});
			d_q[1] <= $signed({v_q[1][4*CRD_W+CRD_W-1], v_q[1][4*CRD_W +: CRD_W]})
				- $signed({v_q[0][4*CRD_W+CRD_W-1], v_q[0][4*CRD_W +: CRD_W]});
			d_q[2] <= $signed({v_q[2][3*CRD_W+CRD_W-1], v_q[2][3*CRD_W +: CRD_W]})
				- $signed({v_q[0][3*CRD_W+CRD_W-1], v_q[0][3*CRD_W +: CRD_W]});
			d_q[3] <= $signed({v_q[2][4*CRD_W+CRD_W-1], v_q[2][4*CRD_W +: CRD_W]})
				- $signed({v_q[0][4*CRD_W+CRD_W-1], v_q[0][4*CRD_W +: CRD_W]});
			for (int i = 0; i < 3; i++) begin
				d_q[4+i] <= $signed({v_q[1][i*CRD_W+CRD_W-1], v_q[1][i*CRD_W +: CRD_W]})
					- $signed({v_q[0][i*CRD_W+CRD_W-1], v_q[0][i*CRD_W +: CRD_W]});
				d_q[7+i] <= $signed({v_q[2][i*CRD_W+CRD_W-1], v_q[2][i*CRD_W +: CRD_W]})
					- $signed({v_q[0][i*CRD_W+CRD_W-1], v_q[0][i*CRD_W +: CRD_W]});
			end
		end
		if (state_q == ST_ABS) begin
			for (int i = 0; i < 10; i++) begin
				dm_q[i] <= d_q[i][32] ? 32'(-d_q[i]) : 32'(d_q[i]);
				dn_q[i] <= d_q[i][32];
			end
		end
		// multiply pipeline: magnitude product, signed value, pair difference
		prod_s1 <= dm_q[ai] * dm_q[bi];
		neg_s1  <= dn_q[ai] ^ dn_q[bi];
		k_s1    <= k_q;
		sp_s2   <= neg_s1 ? -$signed(PRD_W'(prod_s1)) : $signed(PRD_W'(prod_s1));
		k_s2    <= k_s1;
		if (vld_s2) begin
			if (!k_s2[0])
				p_q <= sp_s2;
			else
				res_q[k_s2[2:1]] <= p_q - sp_s2;
		end
		if (state_q == ST_SGN && res_q[0] == '0)
			deg_q <= 1'b1;
		if (state_q == ST_RNORM && nsts.done) begin
			for (int i = 0; i < 3; i++)
				qt_q[i] <= nq[i];
		end
		if (state_q == ST_TNORM && nsts.done) begin
			for (int i = 0; i < 3; i++)
				tq_q[i] <= nq[i];
			if (nsts.zero)
				deg_q <= 1'b1;
		end
		if (state_q == ST_ACWR && (acc[0][ACC_W] || acc[1][ACC_W] || acc[2][ACC_W]))
			sat_q <= 1'b1;
		if (res_load) begin
			out_data_q <= {qt_q[2], qt_q[1], qt_q[0]};
			out_user_q <= {sat_q, deg_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

>>> design/mvta_ram.sv
// ----------------------------------------------------------------------------
// mvta_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mvta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> design/mvta_norm.sv
// ----------------------------------------------------------------------------
// mvta_norm
// Scales a sign/magnitude 3-vector to unit length in Q1.14: shift search,
// sum of squares, bit-serial square root and bit-serial division.
// ----------------------------------------------------------------------------
module mvta_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mvta_pkg::norm_ctl_t               ctl,
	input  logic [mvta_pkg::MAG_W-1:0]        mag_x,
	input  logic [mvta_pkg::MAG_W-1:0]        mag_y,
	input  logic [mvta_pkg::MAG_W-1:0]        mag_z,
	output mvta_pkg::norm_sts_t               sts,
	output logic signed [mvta_pkg::TAN_W-1:0] q_x,
	output logic signed [mvta_pkg::TAN_W-1:0] q_y,
	output logic signed [mvta_pkg::TAN_W-1:0] q_z
);
	import mvta_pkg::*;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DLD   = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	logic [2:0]              state_q;
	logic [4:0]              cnt_q;
	logic [1:0]              comp_q;
	logic                    done_q;
	logic                    zero_q;
	logic [MAG_W-1:0]        w_q [3];
	logic [2:0]              neg_q;
	logic [2*M_W-1:0]        sq_q;
	logic [2*M_W+1:0]        sum_q;
	logic [32:0]             srem_q;
	logic [31:0]             root_q;
	logic [31:0]             drem_q;
	logic [14:0]             nbits_q;
	logic [14:0]             quo_q;
	logic signed [TAN_W-1:0] q_q [3];

	logic [MAG_W-1:0]   orv;
	logic [M_W-1:0]     mm;
	logic [M_W-1:0]     md;
	logic [32:0]        r2;
	logic [32:0]        trial;
	logic [44:0]        num;
	logic [32:0]        dr;
	logic               qbit;
	logic [14:0]        quo_n;
	logic signed [TAN_W-1:0] qs;

	always_comb begin
		orv = w_q[0] | w_q[1] | w_q[2];
		case (cnt_q[1:0])
			2'd0:    mm = w_q[0][MAG_W-1 -: M_W];
			2'd1:    mm = w_q[1][MAG_W-1 -: M_W];
			default: mm = w_q[2][MAG_W-1 -: M_W];
		endcase
		case (comp_q)
			2'd0:    md = w_q[0][MAG_W-1 -: M_W];
			2'd1:    md = w_q[1][MAG_W-1 -: M_W];
			default: md = w_q[2][MAG_W-1 -: M_W];
		endcase
		r2    = {srem_q[30:0], sum_q[2*M_W+1 -: 2]};
		trial = {root_q[30:0], 2'b01};
		num   = {1'b0, md, 14'd0} + 45'(root_q >> 1);
		dr    = {drem_q, nbits_q[14]};
		qbit  = dr >= {1'b0, root_q};
		quo_n = {quo_q[13:0], qbit};
		qs    = neg_q[comp_q] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			done_q  <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (ctl.start) begin
						state_q <= N_SHIFT;
						cnt_q   <= '0;
					end
				end
				N_SHIFT: begin
					if (orv == '0) begin
						zero_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= N_IDLE;
					end else if (orv[MAG_W-1]) begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= N_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						comp_q  <= '0;
						state_q <= N_DLD;
					end
				end
				N_DLD: begin
					cnt_q   <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd14) begin
						if (comp_q == 2'd2) begin
							zero_q  <= 1'b0;
							done_q  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= N_DLD;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (ctl.start) begin
					w_q[0] <= mag_x;
					w_q[1] <= mag_y;
					w_q[2] <= mag_z;
					neg_q  <= ctl.neg;
					sum_q  <= '0;
				end
			end
			N_SHIFT: begin
				if (orv == '0) begin
					q_q[0] <= '0;
					q_q[1] <= '0;
					q_q[2] <= '0;
				end else if (!orv[MAG_W-1]) begin
					if (orv[MAG_W-1 -: 8] == '0) begin
						for (int i = 0; i < 3; i++)
							w_q[i] <= w_q[i] << 8;
					end else begin
						for (int i = 0; i < 3; i++)
							w_q[i] <= w_q[i] << 1;
					end
				end
			end
			N_SQ: begin
				if (cnt_q != 5'd3)
					sq_q <= mm * mm;
				if (cnt_q != 5'd0)
					sum_q <= sum_q + {2'b00, sq_q};
				srem_q <= '0;
				root_q <= '0;
			end
			N_SQRT: begin
				sum_q <= sum_q << 2;
				if (r2 >= trial) begin
					srem_q <= r2 - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= r2;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			N_DLD: begin
				drem_q  <= 32'(num[44:15]);
				nbits_q <= num[14:0];
				quo_q   <= '0;
			end
			N_DIV: begin
				drem_q  <= qbit ? 32'(dr - {1'b0, root_q}) : dr[31:0];
				nbits_q <= nbits_q << 1;
				quo_q   <= quo_n;
				if (cnt_q == 5'd14)
					q_q[comp_q] <= qs;
			end
			default: ;
		endcase
	end

	assign sts.done = done_q;
	assign sts.zero = zero_q;
	assign q_x = q_q[0];
	assign q_y = q_q[1];
	assign q_z = q_q[2];

endmodule

>>> design/mvta_chk.sv
// ----------------------------------------------------------------------------
// mvta_chk
// Port-level checks of the tangent accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module mvta_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [mvta_pkg::S_DATA_W-1:0] s_axis_tdata,
	input logic [1:0]                    s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mvta_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]                    m_axis_tuser
);
	import mvta_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted before the first finished");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("degenerate and saturated both set");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |-> m_axis_tdata == '0)
		else $error("triangle result carries a tangent");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) >= -16'sd16384
			&& $signed(m_axis_tdata[15:0]) <= 16'sd16384
			&& $signed(m_axis_tdata[31:16]) >= -16'sd16384
			&& $signed(m_axis_tdata[31:16]) <= 16'sd16384
			&& $signed(m_axis_tdata[47:32]) >= -16'sd16384
			&& $signed(m_axis_tdata[47:32]) <= 16'sd16384)
		else $error("tangent component outside unit range");

endmodule

bind mesh_vertex_tangent_accumulator mvta_chk u_mvta_chk (.*);
